// ===== hdl/rme_pkg.sv =====
// shared types, constants and operand decode for the register machine execute block
// no dependencies; compiled first
package rme_pkg;

   localparam int DATA_W           = 64;
   localparam int OPCODE_W         = 4;
   localparam int DEST_W           = 3;
   localparam int IP_BIND_W        = 3;
   localparam int PROG_LEN_W       = 11;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int NUM_REGS_DEFAULT = 6;

   // register map, selected by paddr[2]
   localparam logic CSR_IP_BINDING     = 1'b0;
   localparam logic CSR_PROGRAM_LENGTH = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } opcode_type;

   // first operand names a register
   function automatic logic a_is_reg(opcode_type op);
      logic res;
      case (op) inside
         OP_SETI, OP_GTIR, OP_EQIR: res = 1'b0;
         default:                   res = 1'b1;
      endcase
      return res;
   endfunction

   // second operand names a register
   function automatic logic b_is_reg(opcode_type op);
      logic res;
      case (op) inside
         OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR:
            res = 1'b1;
         default:
            res = 1'b0;
      endcase
      return res;
   endfunction

   function automatic logic is_mul(opcode_type op);
      return (op == OP_MULR) || (op == OP_MULI);
   endfunction

endpackage

// ===== hdl/rme_req_if.sv =====
// instruction channel: valid/ready handshake with one instruction as payload
// depends on rme_pkg for field widths
interface rme_req_if;
   logic                           valid;
   logic                           ready;
   logic [rme_pkg::OPCODE_W-1:0]   opcode;
   logic [rme_pkg::DATA_W-1:0]     operand_a;
   logic [rme_pkg::DATA_W-1:0]     operand_b;
   logic [rme_pkg::DEST_W-1:0]     dest_index;

   modport source (output valid, opcode, operand_a, operand_b, dest_index, input ready);
   modport sink   (input valid, opcode, operand_a, operand_b, dest_index, output ready);
endinterface

// ===== hdl/rme_rsp_if.sv =====
// result channel: valid/ready handshake with one execution result as payload
// depends on rme_pkg for field widths
interface rme_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rme_pkg::DATA_W-1:0]   next_index;
   logic                         halted;
   logic [rme_pkg::DATA_W-1:0]   written_value;
   logic                         bad_index;

   modport source (output valid, next_index, halted, written_value, bad_index, input ready);
   modport sink   (input valid, next_index, halted, written_value, bad_index, output ready);
endinterface

// ===== hdl/rme_alu.sv =====
// execute unit: add, and, or, set, compares, and a 64-bit wrapping multiply
// depends on rme_pkg; the multiply's partial products are registered here
module rme_alu (
   input  logic                        clock,
   input  rme_pkg::opcode_type         op,
   input  logic [rme_pkg::DATA_W-1:0]  a,
   input  logic [rme_pkg::DATA_W-1:0]  b,
   output logic [rme_pkg::DATA_W-1:0]  result
);
   import rme_pkg::*;

   localparam int HALF_W = DATA_W / 2;

   logic [DATA_W-1:0] prod_lo_ff, prod_lo_in;
   logic [HALF_W-1:0] cross_lh_ff, cross_lh_in;
   logic [HALF_W-1:0] cross_hl_ff, cross_hl_in;
   logic [HALF_W-1:0] cross_sum;
   logic [DATA_W-1:0] product;

   // multiply, ahead of the register: partial products, only the low half of the cross terms matters
   always_comb begin
      prod_lo_in  = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
      cross_lh_in = a[HALF_W-1:0] * b[DATA_W-1:HALF_W];
      cross_hl_in = a[DATA_W-1:HALF_W] * b[HALF_W-1:0];
   end

   // operands hold steady while a multiply sits in execute, so these load every cycle
   always_ff @(posedge clock) begin
      prod_lo_ff  <= prod_lo_in;
      cross_lh_ff <= cross_lh_in;
      cross_hl_ff <= cross_hl_in;
   end

   // multiply, after the register: fold the cross terms into the upper half
   always_comb begin
      cross_sum = cross_lh_ff + cross_hl_ff;
      product   = prod_lo_ff + {cross_sum, {HALF_W{1'b0}}};
   end

   // result select
   always_comb begin
      case (op) inside
         OP_ADDR, OP_ADDI:          result = a + b;
         OP_MULR, OP_MULI:          result = product;
         OP_BANR, OP_BANI:          result = a & b;
         OP_BORR, OP_BORI:          result = a | b;
         OP_SETR, OP_SETI:          result = a;
         OP_GTIR, OP_GTRI, OP_GTRR: result = {{(DATA_W-1){1'b0}}, (a > b)};
         default:                   result = {{(DATA_W-1){1'b0}}, (a == b)};
      endcase
   end

endmodule

// ===== hdl/register_machine_execute.sv =====
// Register machine execute block: runs one instruction per transfer on a file of NUM_REGS
// 64-bit registers and returns one result per instruction. An accepted instruction lands
// in an instruction register, executes against the register file and leaves through a
// result register, and a new instruction is taken every cycle while the result register
// has room. Multiply instructions (mulr, muli) hold the execute stage until the 64-bit
// product is built from registered 32-bit partial products, and no new instruction is
// taken until then. Configuration (ip_binding at byte 0, program_length at byte 4) must be
// written over the csr port only while the block is idle; the block itself does not
// enforce this.
// Depends on rme_pkg, rme_req_if, rme_rsp_if and rme_alu.
module register_machine_execute #(
   parameter int NUM_REGS = rme_pkg::NUM_REGS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   rme_req_if.sink                           req_port,
   rme_rsp_if.source                         rsp_port,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rme_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rme_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rme_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rme_pkg::*;

   localparam int IDX_W = $clog2(NUM_REGS);

   // configuration registers
   logic [IP_BIND_W-1:0]  ip_binding_ff;
   logic [PROG_LEN_W-1:0] program_length_ff;
   logic                  csr_write;

   // instruction register
   logic                  instr_valid_ff;
   opcode_type            op_ff;
   logic [DATA_W-1:0]     opa_ff;
   logic [DATA_W-1:0]     opb_ff;
   logic [DEST_W-1:0]     dest_ff;
   logic                  mul_phase_ff;

   // register file
   logic [DATA_W-1:0]     rf_ff [NUM_REGS];
   logic [DATA_W-1:0]     rf_in [NUM_REGS];

   // result register
   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     next_index_ff;
   logic [DATA_W-1:0]     written_ff;
   logic                  bad_ff;

   // execute stage
   logic                  a_ok, b_ok, dest_ok, bad, wr_dest, fire;
   logic [IDX_W-1:0]      a_idx, b_idx, dest_idx, ip_sel;
   logic [DATA_W-1:0]     a_val, b_val, alu_val, ip_base, ip_next;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IP_BINDING:
            csr_prdata = {{(CSR_DATA_W-IP_BIND_W){1'b0}}, ip_binding_ff};
         CSR_PROGRAM_LENGTH:
            csr_prdata = {{(CSR_DATA_W-PROG_LEN_W){1'b0}}, program_length_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_binding_ff     <= '0;
         program_length_ff <= PROG_LEN_W'(1);
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_IP_BINDING:     ip_binding_ff     <= csr_pwdata[IP_BIND_W-1:0];
            CSR_PROGRAM_LENGTH: program_length_ff <= csr_pwdata[PROG_LEN_W-1:0];
         endcase
      end
   end

   // operand decode and index checks
   always_comb begin
      a_ok     = opa_ff < DATA_W'(NUM_REGS);
      b_ok     = opb_ff < DATA_W'(NUM_REGS);
      dest_ok  = 32'(dest_ff) < NUM_REGS;
      a_idx    = opa_ff[IDX_W-1:0];
      b_idx    = opb_ff[IDX_W-1:0];
      dest_idx = IDX_W'(dest_ff);
      ip_sel   = (32'(ip_binding_ff) < NUM_REGS) ? IDX_W'(ip_binding_ff)
                                                  : IDX_W'(NUM_REGS - 1);
      a_val    = (a_is_reg(op_ff) && a_ok) ? rf_ff[a_idx] : opa_ff;
      b_val    = (b_is_reg(op_ff) && b_ok) ? rf_ff[b_idx] : opb_ff;
      bad      = (a_is_reg(op_ff) && !a_ok) || (b_is_reg(op_ff) && !b_ok) || !dest_ok;
      wr_dest  = !bad;
   end

   rme_alu u_alu (
      .clock  (clock),
      .op     (op_ff),
      .a      (a_val),
      .b      (b_val),
      .result (alu_val)
   );

   // destination write lands first, then the bound register steps
   always_comb begin
      ip_base = (wr_dest && (dest_idx == ip_sel)) ? alu_val : rf_ff[ip_sel];
      ip_next = ip_base + DATA_W'(1);
      for (int r = 0; r < NUM_REGS; r++) begin
         if (IDX_W'(r) == ip_sel) begin
            rf_in[r] = ip_next;
         end else if (wr_dest && (IDX_W'(r) == dest_idx)) begin
            rf_in[r] = alu_val;
         end else begin
            rf_in[r] = rf_ff[r];
         end
      end
   end

   // handshake: retire when the product is ready and the result register has room
   assign fire = instr_valid_ff && (!is_mul(op_ff) || mul_phase_ff)
                 && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !instr_valid_ff || fire;

   // instruction register and multiply phase
   always_ff @(posedge clock) begin
      if (reset) begin
         instr_valid_ff <= 1'b0;
         mul_phase_ff   <= 1'b0;
      end else begin
         if (req_port.ready) begin
            instr_valid_ff <= req_port.valid;
         end
         if (fire) begin
            mul_phase_ff <= 1'b0;
         end else if (instr_valid_ff && is_mul(op_ff)) begin
            mul_phase_ff <= 1'b1;
         end
      end
      if (req_port.valid && req_port.ready) begin
         op_ff   <= opcode_type'(req_port.opcode);
         opa_ff  <= req_port.operand_a;
         opb_ff  <= req_port.operand_b;
         dest_ff <= req_port.dest_index;
      end
   end

   // register file update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            rf_ff[r] <= '0;
         end
      end else if (fire) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            rf_ff[r] <= rf_in[r];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         next_index_ff <= ip_next;
         written_ff    <= wr_dest ? alu_val : '0;
         bad_ff        <= bad;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.next_index    = next_index_ff;
   assign rsp_port.written_value = written_ff;
   assign rsp_port.bad_index     = bad_ff;
   // user changes program length only while idle (unenforced): compare after register
   assign rsp_port.halted        = next_index_ff >= DATA_W'(program_length_ff);

   // checks
   mul_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (fire && is_mul(op_ff)) |-> mul_phase_ff)
      else $error("multiply retired before its partial products were registered");

   retire_shows_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("retired instruction did not reach the result register");

   bad_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && bad_ff) |-> (written_ff == '0))
      else $error("flagged instruction reports a nonzero written value");

   no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_port.ready) |-> !fire)
      else $error("instruction retired over a stalled result");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for register_machine_execute: directed and random instruction streams
// depends on rme_pkg, rme_req_if, rme_rsp_if and the register_machine_execute rtl
module tb_top;
   import rme_pkg::*;

   localparam int          NUM_REGS     = NUM_REGS_DEFAULT;
   localparam int          PHASE_ITEMS  = 150;
   localparam int          NUM_PHASES   = 9;
   localparam int          SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_IP_BINDING = {CSR_IP_BINDING, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_PROG_LEN   = {CSR_PROGRAM_LENGTH, 2'b00};
   localparam logic [DATA_W-1:0]     ALL_ONES        = '1;

   typedef struct packed {
      opcode_type              opcode;
      logic [DATA_W-1:0]       operand_a;
      logic [DATA_W-1:0]       operand_b;
      logic [DEST_W-1:0]       dest_index;
   } instr_type;

   typedef struct packed {
      logic [DATA_W-1:0]       next_index;
      logic                    halted;
      logic [DATA_W-1:0]       written_value;
      logic                    bad_index;
   } outcome_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rme_req_if req_bus ();
   rme_rsp_if rsp_bus ();

   register_machine_execute #(.NUM_REGS(NUM_REGS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state: register file and configuration copy
   logic [DATA_W-1:0]     machine_regs [NUM_REGS];
   logic [IP_BIND_W-1:0]  ip_bind_cfg;
   logic [PROG_LEN_W-1:0] prog_len_cfg;

   instr_type   pending_instrs [$];
   outcome_type expected_outcomes [$];

   instr_type   cur_instr;
   bit          instr_busy;
   int          gap_left;
   int          stall_left;
   bit          no_idle;
   int          error_count;
   int          accepted_count;
   int          result_count;
   int          bad_count;
   int          halt_count;
   int          settings_count;
   int unsigned cycle_count;

   always #5 clock = ~clock;

   // operand decode, kept independent of the rtl
   function automatic bit reads_reg_a(opcode_type op);
      case (op)
         OP_SETI, OP_GTIR, OP_EQIR: return 1'b0;
         default:                   return 1'b1;
      endcase
   endfunction

   function automatic bit reads_reg_b(opcode_type op);
      case (op)
         OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // execute one instruction on the model and queue the outcome
   function automatic void execute_instruction(instr_type ins);
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] val;
      logic              bad;
      int                ip;
      outcome_type       res;
      a   = ins.operand_a;
      b   = ins.operand_b;
      val = '0;
      bad = 1'b0;
      if (reads_reg_a(ins.opcode)) begin
         if (ins.operand_a < NUM_REGS) a = machine_regs[ins.operand_a[3:0]];
         else bad = 1'b1;
      end
      if (reads_reg_b(ins.opcode)) begin
         if (ins.operand_b < NUM_REGS) b = machine_regs[ins.operand_b[3:0]];
         else bad = 1'b1;
      end
      if (ins.dest_index >= NUM_REGS) bad = 1'b1;
      if (!bad) begin
         case (ins.opcode)
            OP_ADDR, OP_ADDI:          val = a + b;
            OP_MULR, OP_MULI:          val = a * b;
            OP_BANR, OP_BANI:          val = a & b;
            OP_BORR, OP_BORI:          val = a | b;
            OP_SETR, OP_SETI:          val = a;
            OP_GTIR, OP_GTRI, OP_GTRR: val = (a > b) ? 64'd1 : 64'd0;
            default:                   val = (a == b) ? 64'd1 : 64'd0;
         endcase
         machine_regs[ins.dest_index] = val;
      end
      // out-of-range binding falls back to the top register
      ip = (ip_bind_cfg < NUM_REGS) ? int'(ip_bind_cfg) : NUM_REGS - 1;
      machine_regs[ip] = machine_regs[ip] + 64'd1;
      res.next_index    = machine_regs[ip];
      res.halted        = (machine_regs[ip] >= {{(DATA_W-PROG_LEN_W){1'b0}}, prog_len_cfg});
      res.written_value = val;
      res.bad_index     = bad;
      if (bad) bad_count++;
      if (res.halted) halt_count++;
      expected_outcomes = {expected_outcomes, res};
   endfunction

   // append one instruction to the stimulus queue
   function automatic void queue_instr(instr_type ins);
      pending_instrs = {pending_instrs, ins};
   endfunction

   // register index operand: mostly legal, sometimes out of range
   function automatic logic [DATA_W-1:0] pick_index();
      if ($urandom_range(0, 11) != 0) return DATA_W'($urandom_range(0, NUM_REGS - 1));
      case ($urandom_range(0, 3))
         0:       return DATA_W'($urandom_range(NUM_REGS, 7));
         1:       return ALL_ONES;
         2:       return 64'd1 << $urandom_range(3, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_immediate();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return DATA_W'($urandom_range(0, 20));
         3:       return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic instr_type random_instruction();
      instr_type ins;
      ins.opcode     = opcode_type'($urandom_range(0, 15));
      ins.operand_a  = reads_reg_a(ins.opcode) ? pick_index() : pick_immediate();
      ins.operand_b  = reads_reg_b(ins.opcode) ? pick_index() : pick_immediate();
      ins.dest_index = ($urandom_range(0, 19) == 0) ? DEST_W'($urandom_range(NUM_REGS, 7))
                                                   : DEST_W'($urandom_range(0, NUM_REGS - 1));
      return ins;
   endfunction

   function automatic instr_type make_instr(opcode_type op, logic [DATA_W-1:0] a,
                                            logic [DATA_W-1:0] b, logic [DEST_W-1:0] d);
      instr_type ins;
      ins.opcode     = op;
      ins.operand_a  = a;
      ins.operand_b  = b;
      ins.dest_index = d;
      return ins;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      error_count++;
      $display("mismatch on result %0d: %s got %h expected %h", result_count, what, got, want);
   endtask

   // apb write: setup then access, done when pready is seen in the access phase
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input logic [IP_BIND_W-1:0] ip, input logic [PROG_LEN_W-1:0] len);
      write_csr(ADDR_IP_BINDING, CSR_DATA_W'(ip));
      write_csr(ADDR_PROG_LEN, CSR_DATA_W'(len));
      ip_bind_cfg  = ip;
      prog_len_cfg = len;
      settings_count++;
   endtask

   // wait until every instruction is sent and every result is back, then settle
   task automatic drain();
      while (pending_instrs.size() != 0 || instr_busy || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // instruction driver
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) machine_regs[i] = '0;
         ip_bind_cfg  = '0;
         prog_len_cfg = PROG_LEN_W'(1);
         instr_busy   = 1'b0;
         gap_left     = 0;
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            execute_instruction(cur_instr);
            accepted_count++;
            instr_busy = 1'b0;
            if (!no_idle && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
         end
         if (!instr_busy) begin
            if (gap_left > 0) gap_left--;
            else if (pending_instrs.size() != 0) begin
               cur_instr  = pending_instrs.pop_front();
               instr_busy = 1'b1;
            end
         end
         req_bus.valid      <= instr_busy;
         req_bus.opcode     <= cur_instr.opcode;
         req_bus.operand_a  <= cur_instr.operand_a;
         req_bus.operand_b  <= cur_instr.operand_b;
         req_bus.dest_index <= cur_instr.dest_index;
      end
   end

   // result monitor with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected transfer, next_index", rsp_bus.next_index, '0);
            end else begin
               outcome_type want;
               want = expected_outcomes.pop_front();
               if (rsp_bus.next_index !== want.next_index)
                  report_mismatch("next_index", rsp_bus.next_index, want.next_index);
               if (rsp_bus.halted !== want.halted)
                  report_mismatch("halted", DATA_W'(rsp_bus.halted), DATA_W'(want.halted));
               if (rsp_bus.written_value !== want.written_value)
                  report_mismatch("written_value", rsp_bus.written_value, want.written_value);
               if (rsp_bus.bad_index !== want.bad_index)
                  report_mismatch("bad_index", DATA_W'(rsp_bus.bad_index), DATA_W'(want.bad_index));
            end
         end
         if (stall_left > 0) stall_left--;
         else if (!no_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_outcomes.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      logic [IP_BIND_W-1:0]  phase_ip  [NUM_PHASES];
      logic [PROG_LEN_W-1:0] phase_len [NUM_PHASES];
      clock              = 1'b0;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = '0;
      req_bus.operand_a  = '0;
      req_bus.operand_b  = '0;
      req_bus.dest_index = '0;
      rsp_bus.ready      = 1'b0;
      cur_instr          = '0;
      no_idle            = 1'b0;
      phase_ip  = '{3'd3, 3'd5, 3'd7, 3'd6, 3'd0, 3'd1, 3'd2, 3'd4, 3'($urandom_range(0, 7))};
      phase_len = '{11'd1024, 11'd0, 11'd2047, 11'd17, 11'd1, 11'd300, 11'd64, 11'd1023,
                    11'($urandom_range(0, 2047))};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset settings: binding 0, length 1
      queue_instr(make_instr(OP_SETI, ALL_ONES, ALL_ONES, 3'd1));
      queue_instr(make_instr(OP_SETI, 64'h8000_0000_0000_0001, '0, 3'd2));
      queue_instr(make_instr(OP_ADDI, 64'd1, 64'd1, 3'd3));   // wraps to zero
      queue_instr(make_instr(OP_ADDR, 64'd1, 64'd2, 3'd4));
      queue_instr(make_instr(OP_MULR, 64'd1, 64'd2, 3'd5));
      queue_instr(make_instr(OP_MULI, 64'd2, ALL_ONES, 3'd3));
      queue_instr(make_instr(OP_BANR, 64'd1, 64'd2, 3'd4));
      queue_instr(make_instr(OP_BANI, 64'd2, 64'h5555_5555_5555_5555, 3'd4));
      queue_instr(make_instr(OP_BORR, 64'd3, 64'd2, 3'd5));
      queue_instr(make_instr(OP_BORI, 64'd3, 64'hAAAA_AAAA_AAAA_AAAA, 3'd1));
      // unused operands carry out-of-range values and must not be flagged
      queue_instr(make_instr(OP_SETR, 64'd2, ALL_ONES, 3'd3));
      queue_instr(make_instr(OP_GTIR, ALL_ONES, 64'd2, 3'd4));
      queue_instr(make_instr(OP_GTRI, 64'd2, '0, 3'd5));
      queue_instr(make_instr(OP_GTRR, 64'd1, 64'd2, 3'd3));
      queue_instr(make_instr(OP_EQIR, '0, 64'd4, 3'd4));
      queue_instr(make_instr(OP_EQRI, 64'd1, ALL_ONES, 3'd5));
      queue_instr(make_instr(OP_EQRR, 64'd1, 64'd1, 3'd2));
      // flagged register indices on each operand and on the destination
      queue_instr(make_instr(OP_ADDR, 64'd6, 64'd1, 3'd1));
      queue_instr(make_instr(OP_ADDI, ALL_ONES, 64'd5, 3'd1));
      queue_instr(make_instr(OP_GTRR, 64'd1, 64'd7, 3'd1));
      queue_instr(make_instr(OP_SETI, 64'd9, '0, 3'd6));
      queue_instr(make_instr(OP_SETR, 64'd0, '0, 3'd7));
      // destination is the bound register: write then increment
      queue_instr(make_instr(OP_ADDI, 64'd0, 64'd100, 3'd0));
      queue_instr(make_instr(OP_EQIR, ALL_ONES, 64'd1, 3'd0));
      queue_instr(make_instr(OP_MULR, 64'd2, 64'd3, 3'd0));
      drain();

      // random phases, each under its own binding and program length
      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_settings(phase_ip[p], phase_len[p]);
         no_idle = (p == NUM_PHASES - 1);
         for (int k = 0; k < PHASE_ITEMS; k++) queue_instr(random_instruction());
         drain();
      end

      $display("ran %0d instructions under %0d csr settings, %0d results checked",
               accepted_count, settings_count, result_count);
      $display("%0d results flagged a bad index, %0d reported halt, %0d mismatches",
               bad_count, halt_count, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== register_machine_execute.f =====
hdl/rme_pkg.sv
hdl/rme_req_if.sv
hdl/rme_rsp_if.sv
hdl/rme_alu.sv
hdl/register_machine_execute.sv
sim/tb_top.sv
